// File: sv/tips_pkg.sv
`timescale 1ns / 1ps
// shared types, block templates and constants of the tape image converter
package tips_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] KIND_STOP   = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;

    localparam logic [16:0] SIZE_EXTRA   = 17'd16;
    localparam logic [7:0]  BITCOUNT_TOP = 8'h80;

    localparam logic [5:0] TONE_LEN   = 6'd13;
    localparam logic [5:0] DATA_END   = 6'd34;
    localparam logic [5:0] PAUSE_BASE = 6'd35;
    localparam logic [5:0] PAUSE_LAST = 6'd10;
    localparam logic [5:0] STOP_LAST  = 6'd4;

    // one command handed from the parser to the byte sequencer
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] length;
        logic        trunc;
        logic        blk_end;
    } cmd_t;

    function automatic logic [7:0] tone_byte(input logic data_tone, input logic [3:0] i);
        logic [7:0] b;
        case (i)
            4'd0:    b = 8'h02;
            4'd1:    b = 8'h08;
            4'd5:    b = data_tone ? 8'h97 : 8'h7f;
            4'd6:    b = data_tone ? 8'h8c : 8'h9f;
            4'd7:    b = 8'h78;
            4'd8:    b = 8'h08;
            4'd9:    b = 8'h9b;
            4'd10:   b = 8'h02;
            4'd11:   b = 8'hdf;
            4'd12:   b = 8'h02;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] data_tpl_byte(input logic [4:0] i);
        logic [7:0] b;
        case (i)
            5'd0:    b = 8'h03;
            5'd5:    b = 8'h98;
            5'd8:    b = 8'h80;
            5'd9:    b = 8'hB1;
            5'd10:   b = 8'h03;
            5'd11:   b = 8'h02;
            5'd12:   b = 8'h02;
            5'd13:   b = 8'h57;
            5'd14:   b = 8'h03;
            5'd15:   b = 8'h57;
            5'd16:   b = 8'h03;
            5'd17:   b = 8'hAE;
            5'd18:   b = 8'h06;
            5'd19:   b = 8'hAE;
            5'd20:   b = 8'h06;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] pause_byte(input logic [3:0] i);
        logic [7:0] b;
        case (i)
            4'd0:    b = 8'h02;
            4'd1:    b = 8'h06;
            4'd5:    b = 8'h01;
            4'd6:    b = 8'h80;
            4'd7:    b = 8'h35;
            4'd8:    b = 8'h80;
            4'd9:    b = 8'he0;
            4'd10:   b = 8'h67;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: sv/tips_front.sv
`timescale 1ns / 1ps
// tape block parser: tracks length and body, issues commands to the queue
module tips_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic [7:0]      tap_byte,
    input  logic            end_of_file,
    output logic            push,
    output tips_pkg::cmd_t  push_cmd
);

    localparam logic [1:0] PH_LEN_LO = 2'd0;
    localparam logic [1:0] PH_LEN_HI = 2'd1;
    localparam logic [1:0] PH_FLAG   = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [15:0] blk_len_reg, blk_len_next;
    logic [15:0] remain_reg, remain_next;
    logic        finished_reg, finished_next;
    logic [15:0] new_len;

    assign new_len = {tap_byte, len_lo_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        len_lo_next   = len_lo_reg;
        blk_len_next  = blk_len_reg;
        remain_next   = remain_reg;
        finished_next = finished_reg;
        push          = 1'b0;
        push_cmd.kind    = tips_pkg::KIND_STOP;
        push_cmd.data    = tap_byte;
        push_cmd.length  = blk_len_reg;
        push_cmd.trunc   = 1'b0;
        push_cmd.blk_end = 1'b0;
        if (in_fire && !finished_reg)
        begin
            if (end_of_file)
            begin
                push           = 1'b1;
                push_cmd.trunc = (phase_reg != PH_LEN_LO);
                finished_next  = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_LEN_LO:
                    begin
                        len_lo_next = tap_byte;
                        phase_next  = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        blk_len_next = new_len;
                        if (new_len == 16'd0)
                        begin
                            push           = 1'b1;
                            push_cmd.trunc = 1'b1;
                            finished_next  = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_FLAG;
                        end
                    end
                    PH_FLAG:
                    begin
                        push             = 1'b1;
                        push_cmd.kind    = tips_pkg::KIND_HEADER;
                        push_cmd.blk_end = (blk_len_reg == 16'd1);
                        remain_next      = blk_len_reg - 16'd1;
                        phase_next       = (blk_len_reg == 16'd1) ? PH_LEN_LO : PH_BODY;
                    end
                    default:
                    begin
                        push             = 1'b1;
                        push_cmd.kind    = tips_pkg::KIND_DATA;
                        push_cmd.blk_end = (remain_reg == 16'd1);
                        remain_next      = remain_reg - 16'd1;
                        if (remain_reg == 16'd1)
                        begin
                            phase_next = PH_LEN_LO;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LEN_LO;
            len_lo_reg   <= 8'd0;
            blk_len_reg  <= 16'd0;
            remain_reg   <= 16'd0;
            finished_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            len_lo_reg   <= len_lo_next;
            blk_len_reg  <= blk_len_next;
            remain_reg   <= remain_next;
            finished_reg <= finished_next;
        end
    end

endmodule

// File: sv/tips_fifo.sv
`timescale 1ns / 1ps
// short command queue between parser and byte sequencer
module tips_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tips_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output tips_pkg::cmd_t  head
);

    tips_pkg::cmd_t entries_reg [tips_pkg::QUEUE_DEPTH];
    logic [tips_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [tips_pkg::QPTR_W:0]   count_reg;
    logic                        do_push, do_pop;

    assign full      = (count_reg == (tips_pkg::QPTR_W+1)'(tips_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: sv/tips_back.sv
`timescale 1ns / 1ps
// byte sequencer: expands each queued command into output bytes
module tips_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            no_pause,
    input  logic            head_valid,
    input  tips_pkg::cmd_t  head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            truncated
);

    logic [5:0]  idx_reg;
    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg, trunc_reg;
    logic        load, pause_on, last;
    logic [7:0]  byte_val;
    logic        trunc_val;
    logic [5:0]  d_off, p_off;
    logic [16:0] size;

    assign load     = head_valid && (!out_valid_reg || out_ready);
    assign pause_on = head.blk_end && !no_pause;
    assign size     = {1'b0, head.length} + tips_pkg::SIZE_EXTRA;
    assign d_off    = idx_reg - tips_pkg::TONE_LEN;

    always_comb
    begin
        byte_val  = 8'h00;
        trunc_val = 1'b0;
        last      = 1'b0;
        p_off     = idx_reg - 6'd1;
        case (head.kind)
            tips_pkg::KIND_HEADER:
            begin
                p_off = idx_reg - tips_pkg::PAUSE_BASE;
                if (idx_reg < tips_pkg::TONE_LEN)
                begin
                    byte_val = tips_pkg::tone_byte(head.data[7], idx_reg[3:0]);
                end
                else if (idx_reg < tips_pkg::DATA_END)
                begin
                    // size and bit count patched over the template
                    case (d_off[4:0])
                        5'd1:    byte_val = size[7:0];
                        5'd2:    byte_val = size[15:8];
                        5'd3:    byte_val = {7'd0, size[16]};
                        5'd4:    byte_val = 8'h00;
                        5'd5:    byte_val = {head.length[4:0], 3'b000};
                        5'd6:    byte_val = head.length[12:5];
                        5'd7:    byte_val = {5'd0, head.length[15:13]};
                        5'd8:    byte_val = tips_pkg::BITCOUNT_TOP;
                        default: byte_val = tips_pkg::data_tpl_byte(d_off[4:0]);
                    endcase
                end
                else if (idx_reg == tips_pkg::DATA_END)
                begin
                    byte_val = head.data;
                end
                else
                begin
                    byte_val = tips_pkg::pause_byte(p_off[3:0]);
                end
                last = pause_on ? (p_off == tips_pkg::PAUSE_LAST)
                                : (idx_reg == tips_pkg::DATA_END);
            end
            tips_pkg::KIND_DATA:
            begin
                byte_val = (idx_reg == 6'd0) ? head.data : tips_pkg::pause_byte(p_off[3:0]);
                last     = pause_on ? (p_off == tips_pkg::PAUSE_LAST) : (idx_reg == 6'd0);
            end
            default:
            begin
                trunc_val = head.trunc;
                last      = (idx_reg == tips_pkg::STOP_LAST);
            end
        endcase
    end

    assign pop = load && last;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= byte_val;
            last_reg  <= last;
            trunc_reg <= trunc_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= head_valid;
            end
            if (load)
            begin
                idx_reg <= last ? 6'd0 : idx_reg + 6'd1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = byte_reg;
    assign run_last  = last_reg;
    assign truncated = trunc_reg;

endmodule

// File: sv/tape_image_to_pulse_stream.sv
`timescale 1ns / 1ps
// top level: tape image byte stream in, pulse player block stream out
// the first result byte is registered in the command queue, then in the output register
// throughput: one output byte per cycle while out_ready holds; a body byte
// yields one output byte (twelve with a pause), a flag byte 35 to 46; inputs
// flow at one per cycle until the four-entry command queue fills behind the byte sequencer
// reset clears parser, queue and output; no_pause resets to zero
module tape_image_to_pulse_stream (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       no_pause,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] tap_byte,
    input  logic       end_of_file,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       truncated
);

    logic           no_pause_reg;
    logic           in_fire, push, pop, full, not_empty;
    tips_pkg::cmd_t push_cmd, head;

    assign cfg_ready = 1'b1;
    assign in_ready  = !full;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_pause_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            no_pause_reg <= no_pause;
        end
    end

    tips_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .tap_byte    (tap_byte),
        .end_of_file (end_of_file),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    tips_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    tips_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .no_pause   (no_pause_reg),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .truncated  (truncated)
    );

endmodule

// File: test/tb_tape_image_to_pulse_stream.sv
`timescale 1ns / 1ps
// testbench of the tape image to pulse stream converter: directed and random tape files checked byte by byte
module tb_tape_image_to_pulse_stream;

    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int RANDOM_ITEMS   = 200;
    localparam int HOLD_AT_RESULT = 350;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 100;

    localparam logic [7:0]  FLAG_SPLIT   = 8'd128;
    localparam logic [31:0] SIZE_EXTRA   = 32'd16;
    localparam logic [7:0]  BITCOUNT_TOP = 8'h80;

    localparam logic [7:0] HEADER_TONE [13] = '{8'h02, 8'h08, 8'h00, 8'h00, 8'h00, 8'h7f,
                                                8'h9f, 8'h78, 8'h08, 8'h9b, 8'h02, 8'hdf,
                                                8'h02};
    localparam logic [7:0] DATA_TONE [13]   = '{8'h02, 8'h08, 8'h00, 8'h00, 8'h00, 8'h97,
                                                8'h8c, 8'h78, 8'h08, 8'h9b, 8'h02, 8'hdf,
                                                8'h02};
    localparam logic [7:0] DATA_BLOCK [21]  = '{8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h98,
                                                8'h00, 8'h00, 8'h80, 8'hB1, 8'h03, 8'h02,
                                                8'h02, 8'h57, 8'h03, 8'h57, 8'h03, 8'hAE,
                                                8'h06, 8'hAE, 8'h06};
    localparam logic [7:0] PAUSE_BLOCK [11] = '{8'h02, 8'h06, 8'h00, 8'h00, 8'h00, 8'h01,
                                                8'h80, 8'h35, 8'h80, 8'he0, 8'h67};

    typedef enum logic [1:0] {WANT_LEN_LO, WANT_LEN_HI, WANT_FLAG, IN_BODY} tape_phase_e;
    typedef enum logic [1:0] {END_AT_BOUNDARY, END_MID_BLOCK, END_ZERO_LENGTH} file_end_e;

    typedef struct packed {
        logic [7:0] tap;
        logic       eof;
    } tape_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       trunc;
    } pulse_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_no_pause = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] tap_byte = 8'h00;
    logic       end_of_file = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       truncated;

    tape_item_t  pending_items[$];
    pulse_byte_t expected_bytes[$];
    pulse_byte_t burst_bytes[$];

    // converter state as predicted
    tape_phase_e conv_phase = WANT_LEN_LO;
    logic [7:0]  conv_len_lo = 8'h00;
    logic [15:0] conv_len = 16'h0000;
    logic [15:0] conv_left = 16'h0000;
    logic        conv_done = 1'b0;
    logic        pause_off = 1'b0;

    int send_wait = 0;
    int send_streak = 0;
    int recv_wait = 0;
    int recv_streak = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int results_seen = 0;
    int error_count = 0;
    int cycle_count = 0;

    tape_image_to_pulse_stream i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .no_pause    (cfg_no_pause),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .tap_byte    (tap_byte),
        .end_of_file (end_of_file),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .truncated   (truncated)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // idle cycles before the next transfer, with occasional runs of back-to-back transfers
    function automatic int draw_idle(inout int streak);
        if (streak > 0)
        begin
            streak--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            streak = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    task automatic stage_byte(input logic [7:0] b, input logic tr);
        burst_bytes.push_back(pulse_byte_t'({b, 1'b0, tr}));
    endtask

    task automatic stage_stop(input logic tr);
        int k;
        for (k = 0; k < 5; k++)
            stage_byte(8'h00, tr);
        conv_done = 1'b1;
    endtask

    task automatic stage_pause;
        int k;
        if (!pause_off)
        begin
            for (k = 0; k < 11; k++)
                stage_byte(PAUSE_BLOCK[k], 1'b0);
        end
    endtask

    task automatic predict_tape_byte(input logic [7:0] b, input logic eof);
        logic [31:0] size_field;
        logic [31:0] bit_count;
        logic [7:0]  blk [21];
        pulse_byte_t r;
        int          k;
        if (conv_done)
            return;
        if (eof)
            stage_stop(conv_phase != WANT_LEN_LO);
        else
        begin
            case (conv_phase)
                WANT_LEN_LO:
                begin
                    conv_len_lo = b;
                    conv_phase = WANT_LEN_HI;
                end
                WANT_LEN_HI:
                begin
                    conv_len = {b, conv_len_lo};
                    if (conv_len == 16'h0000)
                        stage_stop(1'b1);
                    else
                        conv_phase = WANT_FLAG;
                end
                WANT_FLAG:
                begin
                    for (k = 0; k < 13; k++)
                        stage_byte((b < FLAG_SPLIT) ? HEADER_TONE[k] : DATA_TONE[k], 1'b0);
                    blk = DATA_BLOCK;
                    size_field = 32'(conv_len) + SIZE_EXTRA;
                    bit_count = 32'(conv_len) << 3;
                    blk[1] = size_field[7:0];
                    blk[2] = size_field[15:8];
                    blk[3] = size_field[23:16];
                    blk[4] = size_field[31:24];
                    blk[5] = bit_count[7:0];
                    blk[6] = bit_count[15:8];
                    blk[7] = bit_count[23:16];
                    blk[8] = BITCOUNT_TOP | bit_count[31:24];
                    for (k = 0; k < 21; k++)
                        stage_byte(blk[k], 1'b0);
                    stage_byte(b, 1'b0);
                    conv_left = conv_len - 16'd1;
                    if (conv_left == 16'h0000)
                    begin
                        stage_pause();
                        conv_phase = WANT_LEN_LO;
                    end
                    else
                        conv_phase = IN_BODY;
                end
                default:
                begin
                    stage_byte(b, 1'b0);
                    conv_left = conv_left - 16'd1;
                    if (conv_left == 16'h0000)
                    begin
                        stage_pause();
                        conv_phase = WANT_LEN_LO;
                    end
                end
            endcase
        end
        for (k = 0; k < burst_bytes.size(); k++)
        begin
            r = burst_bytes[k];
            r.last = (k == burst_bytes.size() - 1);
            expected_bytes.push_back(r);
        end
        burst_bytes.delete();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : item_driver
        tape_item_t item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tap_byte <= 8'h00;
            end_of_file <= 1'b0;
            send_wait <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_tape_byte(tap_byte, end_of_file);
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    in_valid <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    tap_byte <= item.tap;
                    end_of_file <= item.eof;
                    send_wait <= draw_idle(send_streak);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        pulse_byte_t want;
        int          gap;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
            hold_left <= 0;
        end
        else
        begin
            gap = 0;
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected result, actual byte %h last %b trunc %b",
                             $time, out_byte, run_last, truncated);
                    error_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if ({out_byte, run_last, truncated} !== want)
                    begin
                        $display("%0t: mismatch, expected %h/%b/%b actual %h/%b/%b",
                                 $time, want.data, want.last, want.trunc,
                                 out_byte, run_last, truncated);
                        error_count++;
                    end
                end
                results_seen++;
                gap = draw_idle(recv_streak);
            end
            // one long stall so the command queue fills and input stalls
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && results_seen >= HOLD_AT_RESULT)
            begin
                hold_done = 1'b1;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready)
            begin
                out_ready <= (gap == 0);
                recv_wait <= (gap > 0) ? gap - 1 : 0;
            end
            else if (!out_ready)
            begin
                if (recv_wait == 0)
                    out_ready <= 1'b1;
                else
                    recv_wait <= recv_wait - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time, expected_bytes.size());
            $display("FAIL tape_image_to_pulse_stream");
            $finish;
        end
    end

    task automatic offer(input logic [7:0] b, input logic eof);
        pending_items.push_back(tape_item_t'({b, eof}));
    endtask

    // length, flag and body of one well-formed tape block with random content
    task automatic queue_block(input int len, output int n_items);
        int k;
        offer(len[7:0], 1'b0);
        offer(len[15:8], 1'b0);
        for (k = 0; k < len; k++)
            offer(8'($urandom_range(0, 255)), 1'b0);
        n_items = len + 2;
    endtask

    // called at a falling edge; returns once nothing is in flight
    task automatic wait_drained;
        while (pending_items.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_no_pause(input logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_no_pause <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pause_off = v;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int        seg;
        int        queued;
        int        n;
        int        len;
        int        cut;
        int        k;
        file_end_e ending;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_no_pause(1'b0);
        // single-byte block with the lowest flag: pause follows the flag
        offer(8'h01, 1'b0); offer(8'h00, 1'b0); offer(8'h00, 1'b0);
        // last header flag, body byte at the top of the range
        offer(8'h02, 1'b0); offer(8'h00, 1'b0); offer(8'h7F, 1'b0); offer(8'hFF, 1'b0);
        // first data flag
        offer(8'h03, 1'b0); offer(8'h00, 1'b0); offer(8'h80, 1'b0); offer(8'h00, 1'b0);
        offer(8'h55, 1'b0);
        offer(8'h01, 1'b0); offer(8'h00, 1'b0); offer(8'hFF, 1'b0);
        wait_drained();

        write_no_pause(1'b1);
        offer(8'h01, 1'b0); offer(8'h00, 1'b0); offer(8'h7F, 1'b0);
        offer(8'h02, 1'b0); offer(8'h00, 1'b0); offer(8'h80, 1'b0); offer(8'hAA, 1'b0);
        wait_drained();

        for (seg = 0; seg < 4; seg++)
        begin
            write_no_pause(seg[0]);
            queued = 0;
            while (queued < RANDOM_ITEMS / 4)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
                queue_block(len, n);
                queued += n;
            end
            wait_drained();
        end

        ending = file_end_e'($urandom_range(0, 2));
        case (ending)
            END_AT_BOUNDARY:
                offer(8'($urandom_range(0, 255)), 1'b1);
            END_MID_BLOCK:
            begin
                len = $urandom_range(2, 8);
                cut = $urandom_range(1, 3);
                offer(len[7:0], 1'b0);
                if (cut >= 2)
                    offer(8'h00, 1'b0);
                if (cut >= 3)
                begin
                    for (k = 0; k <= $urandom_range(0, len - 2); k++)
                        offer(8'($urandom_range(0, 255)), 1'b0);
                end
                offer(8'($urandom_range(0, 255)), 1'b1);
            end
            default:
            begin
                offer(8'h00, 1'b0);
                offer(8'h00, 1'b0);
            end
        endcase
        // once finished every further transfer must be ignored
        repeat (6) offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0 && expected_bytes.size() == 0)
            $display("PASS tape_image_to_pulse_stream");
        else
            $display("FAIL tape_image_to_pulse_stream");
        $finish;
    end

endmodule
